### sv/fts_pkg.sv
// Shared types and the marker reset constant for the frame transmitter with sum checksum.
// No dependencies.
package fts_pkg;

  localparam logic [7:0] MARKER_RESET = 8'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // One classified request: which bytes the back part has to send for it.
  typedef struct packed {
    logic       open;
    logic       close;
    logic [7:0] marker;
    logic [7:0] length;
    logic [7:0] data;
    logic [7:0] csum;
  } job_t;

  typedef enum logic [1:0] {
    PH_MARKER,
    PH_LENGTH,
    PH_DATA,
    PH_CSUM
  } phase_t;

endpackage

### sv/frame_transmitter_sum_checksum.sv
// Frame transmitter with length prefix and two's complement sum checksum.
// Top level; depends on fts_pkg, fts_front, fts_queue, fts_back.
//
// Each accepted request yields one to four result bytes: marker, length and
// data on the request that opens a frame, data alone for later ones, and the
// checksum after the data byte that completes the frame. Requests are accepted
// one per cycle while the job queue (QUEUE_DEPTH entries) has room; the back
// part's output register sends one result per cycle while a job is queued
// and result_ready does not hold it. start_marker resets to 2 and is written
// through cfg; writing it only while the block is idle binds the user, as the
// block itself does not enforce it.
module frame_transmitter_sum_checksum import fts_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  in_item_t   item,
  output logic       result_valid,
  input  logic       result_ready,
  output out_item_t  result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic push;
  logic full;
  logic pop;
  logic head_valid;
  job_t push_job;
  job_t head;

  fts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .queue_full (full),
    .push       (push),
    .job        (push_job)
  );

  fts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  fts_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### sv/fts_front.sv
// Front part: accepts requests, tracks frame state and builds jobs.
// Depends on fts_pkg.
module fts_front import fts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  in_item_t item,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic     queue_full,
  output logic     push,
  output job_t     job
);

  logic       in_frame;
  logic [7:0] bytes_sent;
  logic [7:0] stored_length;
  logic [7:0] running_sum;
  logic [7:0] start_marker;

  logic       open;
  logic [7:0] len_eff;
  logic [7:0] cnt;
  logic [7:0] sum;

  assign cfg_ready  = 1'b1;
  assign item_ready = !queue_full;
  assign push       = item_valid && item_ready;

  always_comb begin
    open    = !in_frame;
    len_eff = open ? item.frame_length : stored_length;
    cnt     = (open ? 8'd0 : bytes_sent) + 8'd1;
    sum     = (open ? 8'd0 : running_sum) + item.payload_byte;
    job.open   = open;
    job.close  = (cnt == len_eff);
    job.marker = start_marker;
    job.length = len_eff;
    job.data   = item.payload_byte;
    job.csum   = 8'd0 - sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      bytes_sent    <= 8'd0;
      stored_length <= 8'd0;
      running_sum   <= 8'd0;
      start_marker  <= MARKER_RESET;
    end else begin
      if (cfg_valid) begin
        start_marker <= cfg_data;
      end
      if (push) begin
        in_frame      <= !job.close;
        bytes_sent    <= cnt;
        stored_length <= len_eff;
        running_sum   <= sum;
      end
    end
  end

endmodule

### sv/fts_queue.sv
// Short job queue between the front and back parts.
// Depends on fts_pkg.
module fts_queue import fts_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      priority if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
`endif

endmodule

### sv/fts_back.sv
// Back part: sends for each job those of the marker, length, data and checksum bytes it needs.
// Depends on fts_pkg.
module fts_back import fts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  phase_t    phase;
  phase_t    phase_next;
  phase_t    cur;
  logic      mid;
  logic      mid_next;
  logic      load;
  out_item_t res_next;

  assign cur  = mid ? phase : (head.open ? PH_MARKER : PH_DATA);
  assign load = head_valid && (!result_valid || result_ready);

  // next state
  always_comb begin
    phase_next = phase;
    mid_next   = mid;
    if (load) begin
      if (res_next.run_last) begin
        mid_next = 1'b0;
      end else begin
        mid_next = 1'b1;
        unique case (cur)
          PH_MARKER: phase_next = PH_LENGTH;
          PH_LENGTH: phase_next = PH_DATA;
          PH_DATA:   phase_next = PH_CSUM;
          PH_CSUM:   phase_next = PH_MARKER;
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    res_next.run_last  = 1'b0;
    res_next.frame_end = 1'b0;
    unique case (cur)
      PH_MARKER: res_next.tx_byte = head.marker;
      PH_LENGTH: res_next.tx_byte = head.length;
      PH_DATA: begin
        res_next.tx_byte  = head.data;
        res_next.run_last = !head.close;
      end
      PH_CSUM: begin
        res_next.tx_byte   = head.csum;
        res_next.run_last  = 1'b1;
        res_next.frame_end = 1'b1;
      end
    endcase
    pop = load && res_next.run_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MARKER;
      mid          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      mid   <= mid_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

`ifndef SYNTH
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_end |-> result.run_last)
    else $error("frame end without run last");
  a_mid_has_job: assert property (@(posedge clk) disable iff (rst) mid |-> head_valid)
    else $error("job popped mid sequence");
`endif

endmodule
